>>> src/fbsb_pkg.sv
// Shared types, constants and helpers for the framebuffer sprite blitter.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package fbsb_pkg;

    // Framebuffer geometry.
    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 128;
    localparam int FB_SIZE   = FB_WIDTH * FB_HEIGHT;
    localparam int XW        = $clog2(FB_WIDTH);
    localparam int YW        = $clog2(FB_HEIGHT);
    localparam int AW        = $clog2(FB_SIZE);

    // Width of a position after adding an offset (sign bit plus ten bits).
    localparam int PW = 11;

    // Command queue depth.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Configuration register indexes and reset values.
    localparam logic CFG_KEY_COLOR  = 1'b0;
    localparam logic CFG_KEY_ENABLE = 1'b1;
    localparam logic [15:0] KEY_COLOR_RESET = 16'hF81F;

    // Input command codes.
    typedef enum logic [2:0] {
        CMD_BEGIN = 3'd0,
        CMD_PIXEL = 3'd1,
        CMD_CROSS = 3'd2,
        CMD_FILL  = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    // Operations handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CROSS = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind        kind;
        logic [9:0]      pos_x;
        logic [9:0]      pos_y;
        logic [6:0]      arm;
        logic [15:0]     color;
        logic [AW-1:0]   addr;
        logic            off;
    } t_op;

    // True when a position lies inside the framebuffer.
    function automatic logic on_screen(input logic [PW-1:0] x, input logic [PW-1:0] y);
        return !x[PW-1] && (x < PW'(FB_WIDTH)) && !y[PW-1] && (y < PW'(FB_HEIGHT));
    endfunction

    // Row-major address of an on-screen position.
    function automatic logic [AW-1:0] pix_addr(input logic [PW-1:0] x,
                                               input logic [PW-1:0] y);
        return AW'(y[YW-1:0]) * AW'(FB_WIDTH) + AW'(x[XW-1:0]);
    endfunction

endpackage

>>> src/framebuffer_sprite_blitter_core.sv
// Sprite blitter top level: a read passes through the operation queue, the registered
// framebuffer read port and the result register. Begin-blit items finish in the front
// end; sprite pixels, crosshair arms and fills are drawn by the back end through the
// single framebuffer write port, and a read waits until the previous result has left.
// A 4-entry queue lets input transfers continue while the back end works. Reset clears
// control state, sets key_color 0xF81F and key_enable 1, and leaves pixels undefined.
module framebuffer_sprite_blitter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_cmd,
    input  logic [9:0]    i_pos_x,
    input  logic [9:0]    i_pos_y,
    input  logic [7:0]    i_sprite_width,
    input  logic [7:0]    i_sprite_height,
    input  logic [6:0]    i_arm_length,
    input  logic [15:0]   i_color,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [15:0]   o_pixel_color,
    output logic          o_off_screen
);

    logic           q_full;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;
    fbsb_pkg::t_op  q_in;
    fbsb_pkg::t_op  q_head;

    // Front end: classification and blit tracking.
    fbsb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_sprite_width  (i_sprite_width),
        .i_sprite_height (i_sprite_height),
        .i_arm_length    (i_arm_length),
        .i_color         (i_color),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_op            (q_in)
    );

    // Operation queue.
    fbsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // Back end: framebuffer and drawing sequencer.
    fbsb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_color (o_pixel_color),
        .o_off_screen  (o_off_screen)
    );

endmodule

>>> src/fbsb_front.sv
// Front end: takes input transfers, tracks blit progress, clips and keys
// sprite pixels and turns items into queue operations.
// Depends on fbsb_pkg.
module fbsb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_cmd,
    input  logic [9:0]        i_pos_x,
    input  logic [9:0]        i_pos_y,
    input  logic [7:0]        i_sprite_width,
    input  logic [7:0]        i_sprite_height,
    input  logic [6:0]        i_arm_length,
    input  logic [15:0]       i_color,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_q_full,
    output logic              o_push,
    output fbsb_pkg::t_op     o_op
);

    logic [15:0] r_key_color;
    logic        r_key_enable;
    logic [9:0]  r_org_x, n_org_x;
    logic [9:0]  r_org_y, n_org_y;
    logic [7:0]  r_cols, n_cols;
    logic [7:0]  r_rows, n_rows;
    logic [7:0]  r_col, n_col;
    logic [7:0]  r_row, n_row;
    logic        r_active, n_active;

    logic                        accept;
    logic [fbsb_pkg::PW-1:0]     spr_x;
    logic [fbsb_pkg::PW-1:0]     spr_y;
    logic [fbsb_pkg::PW-1:0]     rd_x;
    logic [fbsb_pkg::PW-1:0]     rd_y;
    logic [8:0]                  col_inc;
    logic [8:0]                  row_inc;
    logic                        spr_write;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Sprite pixel position and the write decision (clip and color key).
    assign spr_x = {r_org_x[9], r_org_x} + {3'b000, r_col};
    assign spr_y = {r_org_y[9], r_org_y} + {3'b000, r_row};
    assign spr_write = fbsb_pkg::on_screen(spr_x, spr_y)
                       && (!r_key_enable || (i_color != r_key_color));
    assign rd_x = {i_pos_x[9], i_pos_x};
    assign rd_y = {i_pos_y[9], i_pos_y};
    assign col_inc = {1'b0, r_col} + 9'd1;
    assign row_inc = {1'b0, r_row} + 9'd1;

    // Classification of one item and the next blit state.
    always_comb begin
        n_org_x  = r_org_x;
        n_org_y  = r_org_y;
        n_cols   = r_cols;
        n_rows   = r_rows;
        n_col    = r_col;
        n_row    = r_row;
        n_active = r_active;
        o_push   = 1'b0;
        o_op.kind  = fbsb_pkg::OP_WRITE;
        o_op.pos_x = i_pos_x;
        o_op.pos_y = i_pos_y;
        o_op.arm   = i_arm_length;
        o_op.color = i_color;
        o_op.addr  = fbsb_pkg::pix_addr(spr_x, spr_y);
        o_op.off   = 1'b0;
        case (fbsb_pkg::t_cmd'(i_cmd))
            fbsb_pkg::CMD_BEGIN: begin
                n_org_x  = i_pos_x;
                n_org_y  = i_pos_y;
                n_cols   = i_sprite_width;
                n_rows   = i_sprite_height;
                n_col    = '0;
                n_row    = '0;
                n_active = (i_sprite_width != 8'd0) && (i_sprite_height != 8'd0);
            end
            fbsb_pkg::CMD_PIXEL: begin
                if (r_active) begin
                    o_push = spr_write;
                    n_col  = col_inc[7:0];
                    if (col_inc >= {1'b0, r_cols}) begin
                        n_col = '0;
                        n_row = row_inc[7:0];
                        if (row_inc >= {1'b0, r_rows}) begin
                            n_row    = '0;
                            n_active = 1'b0;
                        end
                    end
                end
            end
            fbsb_pkg::CMD_CROSS: begin
                o_push    = 1'b1;
                o_op.kind = fbsb_pkg::OP_CROSS;
            end
            fbsb_pkg::CMD_FILL: begin
                o_push    = 1'b1;
                o_op.kind = fbsb_pkg::OP_FILL;
            end
            fbsb_pkg::CMD_READ: begin
                o_push    = 1'b1;
                o_op.kind = fbsb_pkg::OP_READ;
                o_op.addr = fbsb_pkg::pix_addr(rd_x, rd_y);
                o_op.off  = !fbsb_pkg::on_screen(rd_x, rd_y);
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
        if (!accept) begin
            o_push = 1'b0;
        end
    end

    // Blit state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_cols   <= '0;
            r_rows   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
        end else if (accept) begin
            r_org_x  <= n_org_x;
            r_org_y  <= n_org_y;
            r_cols   <= n_cols;
            r_rows   <= n_rows;
            r_col    <= n_col;
            r_row    <= n_row;
            r_active <= n_active;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_color  <= fbsb_pkg::KEY_COLOR_RESET;
            r_key_enable <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fbsb_pkg::CFG_KEY_COLOR) begin
                r_key_color <= i_cfg_data;
            end else begin
                r_key_enable <= i_cfg_data[0];
            end
        end
    end

endmodule

>>> src/fbsb_queue.sv
// Short first-in first-out queue of operations between front and back end.
// Depends on fbsb_pkg.
module fbsb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fbsb_pkg::t_op  i_op,
    output logic           o_full,
    output logic           o_valid,
    output fbsb_pkg::t_op  o_head,
    input  logic           i_pop
);

    fbsb_pkg::t_op                r_slot [fbsb_pkg::QDEPTH];
    logic [fbsb_pkg::QAW-1:0]     r_wp;
    logic [fbsb_pkg::QAW-1:0]     r_rp;
    logic [fbsb_pkg::QAW:0]       r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == (fbsb_pkg::QAW+1)'(fbsb_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/fbsb_back.sv
// Back end: owns the framebuffer memory, carries out writes, crosshair
// arms, fills and reads, and holds the result register.
// Depends on fbsb_pkg.
module fbsb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  fbsb_pkg::t_op  i_q_head,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [15:0]    o_pixel_color,
    output logic           o_off_screen
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HLINE = 4'b0010,
        ST_VLINE = 4'b0100,
        ST_FILL  = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [7:0]                r_d, n_d;
    logic [9:0]                r_cx;
    logic [9:0]                r_cy;
    logic [6:0]                r_arm;
    logic [15:0]               r_color;
    logic [fbsb_pkg::AW-1:0]   r_fill_addr, n_fill_addr;
    logic                      r_rd_pend;
    logic                      r_rd_off;
    logic [15:0]               r_rd_data;
    logic                      r_out_valid;
    logic [15:0]               r_out_color;
    logic                      r_out_off;

    logic [15:0]               mem [fbsb_pkg::FB_SIZE];

    logic                      take;
    logic                      rd_en;
    logic                      wr_en;
    logic [fbsb_pkg::AW-1:0]   wr_addr;
    logic [15:0]               wr_data;
    logic [fbsb_pkg::PW-1:0]   cx_ext;
    logic [fbsb_pkg::PW-1:0]   cy_ext;
    logic [fbsb_pkg::PW-1:0]   d_ext;
    logic [fbsb_pkg::PW-1:0]   arm_x;
    logic [fbsb_pkg::PW-1:0]   arm_y;
    logic                      arm_end;

    // A read is taken only when the result path is free.
    assign take = i_q_valid && (r_state == ST_IDLE)
                  && ((i_q_head.kind != fbsb_pkg::OP_READ) || (!r_out_valid && !r_rd_pend));
    assign o_q_pop = take;
    assign rd_en   = take && (i_q_head.kind == fbsb_pkg::OP_READ);

    // Current crosshair point.
    assign cx_ext  = {r_cx[9], r_cx};
    assign cy_ext  = {r_cy[9], r_cy};
    assign d_ext   = {{3{r_d[7]}}, r_d};
    assign arm_x   = (r_state == ST_HLINE) ? cx_ext + d_ext : cx_ext;
    assign arm_y   = (r_state == ST_HLINE) ? cy_ext : cy_ext + d_ext;
    assign arm_end = (r_d == {1'b0, r_arm});

    // Sequencer and memory write selection.
    always_comb begin
        n_state     = r_state;
        n_d         = r_d;
        n_fill_addr = r_fill_addr;
        wr_en       = 1'b0;
        wr_addr     = fbsb_pkg::pix_addr(arm_x, arm_y);
        wr_data     = r_color;
        case (r_state)
            ST_IDLE: begin
                n_d         = 8'(~{1'b0, i_q_head.arm} + 8'd1);
                n_fill_addr = '0;
                if (take) begin
                    case (i_q_head.kind)
                        fbsb_pkg::OP_WRITE: begin
                            wr_en   = 1'b1;
                            wr_addr = i_q_head.addr;
                            wr_data = i_q_head.color;
                        end
                        fbsb_pkg::OP_CROSS: n_state = ST_HLINE;
                        fbsb_pkg::OP_FILL:  n_state = ST_FILL;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_HLINE: begin
                wr_en = fbsb_pkg::on_screen(arm_x, arm_y);
                n_d   = r_d + 8'd1;
                if (arm_end) begin
                    n_d     = 8'(~{1'b0, r_arm} + 8'd1);
                    n_state = ST_VLINE;
                end
            end
            ST_VLINE: begin
                wr_en = fbsb_pkg::on_screen(arm_x, arm_y);
                n_d   = r_d + 8'd1;
                if (arm_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FILL: begin
                wr_en       = 1'b1;
                wr_addr     = r_fill_addr;
                n_fill_addr = r_fill_addr + 1'b1;
                if (r_fill_addr == fbsb_pkg::AW'(fbsb_pkg::FB_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Framebuffer memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[i_q_head.addr];
        end
    end

    // Control registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_d         <= '0;
            r_fill_addr <= '0;
        end else begin
            r_state     <= n_state;
            r_d         <= n_d;
            r_fill_addr <= n_fill_addr;
        end
    end

    // Operation payload latched whenever an operation is taken from the queue.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cx     <= i_q_head.pos_x;
            r_cy     <= i_q_head.pos_y;
            r_arm    <= i_q_head.arm;
            r_color  <= i_q_head.color;
            r_rd_off <= i_q_head.off;
        end
    end

    // Read pending flag and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= rd_en;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_out_color <= r_rd_off ? 16'd0 : r_rd_data;
            r_out_off   <= r_rd_off;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_out_color;
    assign o_off_screen  = r_out_off;

endmodule

>>> src/fbsb_checker.sv
// Port-level checks for the sprite blitter top level, attached by bind.
// Depends on framebuffer_sprite_blitter_core.
module fbsb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic [15:0]   o_pixel_color,
    input  logic          o_off_screen
);

    // A waiting result keeps its value until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_color)
                                        && $stable(o_off_screen))
        else $error("result changed before its transfer");

    // An off-screen read always reports color zero.
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_off_screen |-> o_pixel_color == 16'd0)
        else $error("off-screen read returned a nonzero color");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind framebuffer_sprite_blitter_core fbsb_checker u_fbsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_color (o_pixel_color),
    .o_off_screen  (o_off_screen)
);

>>> dv/framebuffer_sprite_blitter_core_test.sv
// Self-checking testbench for the framebuffer sprite blitter core.
// Depends on src/fbsb_pkg.sv and src/framebuffer_sprite_blitter_core.sv; it keeps its own
// copy of the framebuffer and blit state to predict every read result.
`timescale 1ns / 100ps

module framebuffer_sprite_blitter_core_test;

    // Command codes that the block must ignore.
    localparam logic [2:0] CMD_RESERVED_MIN = 3'd5;
    localparam logic [2:0] CMD_RESERVED_MAX = 3'd7;

    // The settle time leaves margin after the last result.
    localparam int SETTLE_CYCLES  = 8;
    // Up to five fills may be queued or running with no transfer at all.
    localparam int WATCHDOG_LIMIT = 500000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 300;

    typedef struct {
        logic [2:0]        cmd;
        logic signed [9:0] pos_x;
        logic signed [9:0] pos_y;
        logic [7:0]        width;
        logic [7:0]        height;
        logic [6:0]        arm;
        logic [15:0]       color;
    } t_blit_item;

    typedef struct {
        logic [15:0] color;
        logic        off;
    } t_read_result;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [2:0]  in_cmd    = '0;
    logic [9:0]  in_pos_x  = '0;
    logic [9:0]  in_pos_y  = '0;
    logic [7:0]  in_width  = '0;
    logic [7:0]  in_height = '0;
    logic [6:0]  in_arm    = '0;
    logic [15:0] in_color  = '0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [15:0] o_pixel_color;
    logic        o_off_screen;

    // Shadow of the block: framebuffer, blit progress and key registers.
    logic [15:0] frame_model [fbsb_pkg::FB_SIZE];
    int          blit_org_x;
    int          blit_org_y;
    int          blit_cols;
    int          blit_rows;
    int          blit_col;
    int          blit_row;
    bit          blit_busy;
    logic [15:0] key_color_cfg  = fbsb_pkg::KEY_COLOR_RESET;
    bit          key_enable_cfg = 1'b1;

    t_read_result expected_pixels [$];
    int           effective_items = 0;
    int           fail_count      = 0;
    int           quiet_cycles    = 0;
    int           hold_off_cycles = 0;
    bit           tx_idle_on      = 1'b0;
    bit           rx_idle_on      = 1'b0;

    framebuffer_sprite_blitter_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (in_cmd),
        .i_pos_x         (in_pos_x),
        .i_pos_y         (in_pos_y),
        .i_sprite_width  (in_width),
        .i_sprite_height (in_height),
        .i_arm_length    (in_arm),
        .i_color         (in_color),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_pixel_color   (o_pixel_color),
        .o_off_screen    (o_off_screen)
    );

    always #4 clk = ~clk;

    function automatic bit on_frame(input int x, input int y);
        return x >= 0 && x < fbsb_pkg::FB_WIDTH && y >= 0 && y < fbsb_pkg::FB_HEIGHT;
    endfunction

    function automatic void plot_pixel(input int x, input int y, input logic [15:0] c);
        if (on_frame(x, y)) begin
            frame_model[y * fbsb_pkg::FB_WIDTH + x] = c;
        end
    endfunction

    // Applies one accepted command to the shadow state. Returns 0 when the block
    // ignores the command, so that it does not count as stimulus.
    function automatic bit update_frame_model(input t_blit_item it);
        int px;
        int py;
        int d;
        t_read_result res;
        px = it.pos_x;
        py = it.pos_y;
        case (it.cmd)
            fbsb_pkg::CMD_BEGIN: begin
                blit_org_x = it.pos_x;
                blit_org_y = it.pos_y;
                blit_cols  = it.width;
                blit_rows  = it.height;
                blit_col   = 0;
                blit_row   = 0;
                blit_busy  = (it.width != 0) && (it.height != 0);
            end
            fbsb_pkg::CMD_PIXEL: begin
                if (!blit_busy) begin
                    return 1'b0;
                end
                if (!key_enable_cfg || it.color != key_color_cfg) begin
                    plot_pixel(blit_org_x + blit_col, blit_org_y + blit_row, it.color);
                end
                blit_col++;
                if (blit_col >= blit_cols) begin
                    blit_col = 0;
                    blit_row++;
                    if (blit_row >= blit_rows) begin
                        blit_row  = 0;
                        blit_busy = 1'b0;
                    end
                end
            end
            fbsb_pkg::CMD_CROSS: begin
                for (d = -int'(it.arm); d <= int'(it.arm); d++) begin
                    plot_pixel(px + d, py, it.color);
                end
                for (d = -int'(it.arm); d <= int'(it.arm); d++) begin
                    plot_pixel(px, py + d, it.color);
                end
            end
            fbsb_pkg::CMD_FILL: begin
                foreach (frame_model[k]) begin
                    frame_model[k] = it.color;
                end
            end
            fbsb_pkg::CMD_READ: begin
                if (on_frame(px, py)) begin
                    res = '{frame_model[py * fbsb_pkg::FB_WIDTH + px], 1'b0};
                end else begin
                    res = '{16'h0000, 1'b1};
                end
                expected_pixels.push_back(res);
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void note_failure(input string what, input t_read_result want,
                                         input t_read_result got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected color %h off %b, got color %h off %b",
                     $time, what, want.color, want.off, got.color, got.off);
        end
    endfunction

    // Every field random, so that fields a command does not use carry noise.
    function automatic t_blit_item scrambled_item(input logic [2:0] cmd);
        t_blit_item it;
        it.cmd    = cmd;
        it.pos_x  = 10'($urandom);
        it.pos_y  = 10'($urandom);
        it.width  = 8'($urandom);
        it.height = 8'($urandom);
        it.arm    = 7'($urandom);
        it.color  = 16'($urandom);
        return it;
    endfunction

    // Mostly near the screen so that clipping edges are hit, sometimes anywhere.
    function automatic int pick_coord(input int span);
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(0, 1023) - 512;
        end
        return $urandom_range(0, span + 15) - 8;
    endfunction

    // Offers one command and holds it until the transfer, then updates the shadow.
    task automatic send_command(input t_blit_item it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_cmd    <= it.cmd;
        in_pos_x  <= it.pos_x;
        in_pos_y  <= it.pos_y;
        in_width  <= it.width;
        in_height <= it.height;
        in_arm    <= it.arm;
        in_color  <= it.color;
        in_valid  <= 1'b1;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        if (update_frame_model(it)) begin
            effective_items++;
        end
    endtask

    task automatic send_begin(input int x, input int y, input int w, input int h);
        t_blit_item it;
        it        = scrambled_item(fbsb_pkg::CMD_BEGIN);
        it.pos_x  = 10'(x);
        it.pos_y  = 10'(y);
        it.width  = 8'(w);
        it.height = 8'(h);
        send_command(it);
    endtask

    task automatic send_pixel(input logic [15:0] c);
        t_blit_item it;
        it       = scrambled_item(fbsb_pkg::CMD_PIXEL);
        it.color = c;
        send_command(it);
    endtask

    task automatic send_cross(input int x, input int y, input int arm, input logic [15:0] c);
        t_blit_item it;
        it       = scrambled_item(fbsb_pkg::CMD_CROSS);
        it.pos_x = 10'(x);
        it.pos_y = 10'(y);
        it.arm   = 7'(arm);
        it.color = c;
        send_command(it);
    endtask

    task automatic send_fill(input logic [15:0] c);
        t_blit_item it;
        it       = scrambled_item(fbsb_pkg::CMD_FILL);
        it.color = c;
        send_command(it);
    endtask

    task automatic send_read(input int x, input int y);
        t_blit_item it;
        it       = scrambled_item(fbsb_pkg::CMD_READ);
        it.pos_x = 10'(x);
        it.pos_y = 10'(y);
        send_command(it);
    endtask

    task automatic send_code(input logic [2:0] cmd);
        send_command(scrambled_item(cmd));
    endtask

    task automatic send_random_read();
        if ($urandom_range(0, 3) != 0) begin
            send_read($urandom_range(0, fbsb_pkg::FB_WIDTH - 1),
                      $urandom_range(0, fbsb_pkg::FB_HEIGHT - 1));
        end else begin
            send_read($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    task automatic send_random_cross();
        int arm;
        arm = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 16) : $urandom_range(0, 127);
        send_cross(pick_coord(fbsb_pkg::FB_WIDTH), pick_coord(fbsb_pkg::FB_HEIGHT), arm,
                   16'($urandom));
    endtask

    // A begin blit and its pixel stream, sometimes cut short or interleaved with
    // other commands, followed by reads inside the sprite.
    task automatic send_random_sprite();
        int r;
        int w;
        int h;
        int ox;
        int oy;
        int npix;
        int cut;
        int k;
        r = $urandom_range(0, 199);
        if (r < 10) begin
            w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            h = (w == 0) ? $urandom_range(0, 8) : 0;
        end else if (r < 13) begin
            if ($urandom_range(0, 1)) begin
                w = $urandom_range(100, 255);
                h = 1;
            end else begin
                w = 1;
                h = $urandom_range(100, 255);
            end
        end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
        end
        ox   = pick_coord(fbsb_pkg::FB_WIDTH);
        oy   = pick_coord(fbsb_pkg::FB_HEIGHT);
        npix = w * h;
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix) : npix;
        send_begin(ox, oy, w, h);
        for (k = 0; k < cut; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1)) begin
                    send_random_read();
                end else begin
                    send_cross(pick_coord(fbsb_pkg::FB_WIDTH), pick_coord(fbsb_pkg::FB_HEIGHT),
                               $urandom_range(0, 8), 16'($urandom));
                end
            end
            send_pixel(($urandom_range(0, 3) == 0) ? key_color_cfg : 16'($urandom));
        end
        if (npix > 0) begin
            repeat (2) send_read(ox + $urandom_range(0, w - 1), oy + $urandom_range(0, h - 1));
        end
    endtask

    task automatic run_random_traffic(input int n);
        int stop_at;
        int r;
        stop_at = effective_items + n;
        while (effective_items < stop_at) begin
            r = $urandom_range(0, 199);
            if (r < 100) begin
                send_random_sprite();
            end else if (r < 150) begin
                send_random_read();
            end else if (r < 175) begin
                send_random_cross();
            end else if (r < 183) begin
                send_pixel(16'($urandom));
            end else if (r < 186) begin
                send_code(3'($urandom_range(CMD_RESERVED_MIN, CMD_RESERVED_MAX)));
            end else if (r < 193) begin
                send_fill(16'($urandom));
            end else begin
                send_random_read();
            end
        end
    endtask

    // A trailing read cannot complete before the commands ahead of it, so its
    // result marks the block as idle.
    task automatic wait_for_idle();
        send_read(0, 0);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic index, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == fbsb_pkg::CFG_KEY_COLOR) begin
            key_color_cfg = data;
        end else begin
            key_enable_cfg = data[0];
        end
    endtask

    task automatic apply_reset();
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Runs with the reset key settings. The fill comes first so that no read
    // ever touches an unwritten pixel.
    task automatic test_directed_cases();
        send_fill(16'h1234);
        send_read(0, 0);
        send_read(fbsb_pkg::FB_WIDTH - 1, fbsb_pkg::FB_HEIGHT - 1);
        send_read(-512, -512);
        send_read(511, 511);
        send_read(fbsb_pkg::FB_WIDTH, 0);
        send_read(0, -1);
        // Sprite pixels with no blit running, and sprites with no area.
        send_pixel(16'hFFFF);
        send_begin(0, 0, 0, 4);
        send_pixel(16'hABCD);
        send_begin(0, 0, 3, 0);
        // A 2x2 sprite straddling the top right corner; its one visible pixel is
        // key colored, and other commands arrive in the middle of it.
        send_begin(fbsb_pkg::FB_WIDTH - 1, -1, 2, 2);
        send_pixel(16'h0001);
        send_cross(5, 5, 0, 16'h00FF);
        send_read(5, 5);
        send_pixel(16'h0002);
        send_pixel(fbsb_pkg::KEY_COLOR_RESET);
        send_pixel(16'hFFFF);
        send_pixel(16'h7777);
        send_read(fbsb_pkg::FB_WIDTH - 1, 0);
        // A new begin blit restarts the stream.
        send_begin(10, 10, 255, 255);
        send_pixel(16'h5555);
        send_begin(-512, 511, 1, 1);
        send_pixel(16'h0000);
        send_read(10, 10);
        send_read(11, 10);
        // Longest arms, clipped on both sides, then entirely off screen.
        send_cross(64, 64, 127, 16'h0000);
        send_read(0, 64);
        send_read(64, fbsb_pkg::FB_HEIGHT - 1);
        send_cross(-512, 0, 127, 16'hFFFF);
        send_code(CMD_RESERVED_MIN);
        send_code(CMD_RESERVED_MAX);
    endtask

    task automatic test_default_key_traffic();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random_traffic(PHASE_ITEMS);
    endtask

    task automatic test_black_key_back_to_back();
        wait_for_idle();
        write_config(fbsb_pkg::CFG_KEY_COLOR, 16'h0000);
        write_config(fbsb_pkg::CFG_KEY_ENABLE, {15'($urandom), 1'b1});
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_traffic(PHASE_ITEMS);
    endtask

    // The sink stops taking results for a long stretch while reads keep coming,
    // so the queue fills and the input stalls.
    task automatic test_output_backpressure();
        tx_idle_on      = 1'b0;
        rx_idle_on      = 1'b0;
        hold_off_cycles = 400;
        repeat (24) send_random_read();
    endtask

    task automatic test_keying_disabled();
        wait_for_idle();
        write_config(fbsb_pkg::CFG_KEY_COLOR, 16'hFFFF);
        write_config(fbsb_pkg::CFG_KEY_ENABLE, {15'($urandom), 1'b0});
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random_traffic(PHASE_ITEMS);
    endtask

    task automatic test_random_key();
        wait_for_idle();
        write_config(fbsb_pkg::CFG_KEY_COLOR, 16'($urandom));
        write_config(fbsb_pkg::CFG_KEY_ENABLE, {15'($urandom), 1'b1});
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        run_random_traffic(PHASE_ITEMS);
    endtask

    // Result sink: a random stall before each transfer, or a long hold on request.
    initial begin : result_sink
        int stall;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 16) : 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk);
            while (!(o_out_valid === 1'b1 && out_ready) && hold_off_cycles == 0);
        end
    end

    // Compare each result transfer with the oldest expected read.
    always @(posedge clk) begin : check_results
        t_read_result want;
        t_read_result got;
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            got = '{o_pixel_color, o_off_screen};
            if (expected_pixels.size() == 0) begin
                note_failure("unexpected read result", '{16'h0000, 1'b0}, got);
            end else begin
                want = expected_pixels.pop_front();
                if (got.color !== want.color || got.off !== want.off) begin
                    note_failure("read result mismatch", want, got);
                end
            end
        end
    end

    // Ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready === 1'b1)
                   || (o_out_valid === 1'b1 && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[framebuffer_sprite_blitter_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        apply_reset();
        test_directed_cases();
        test_default_key_traffic();
        test_black_key_back_to_back();
        test_output_backpressure();
        test_keying_disabled();
        test_random_key();
        wait_for_idle();
        if (fail_count == 0) begin
            $display("[framebuffer_sprite_blitter_core] OK");
        end else begin
            $display("[framebuffer_sprite_blitter_core] ERROR");
        end
        $finish;
    end

endmodule
